// ===== src/prp_pkg.sv =====
`timescale 1ns / 1ps
// shared types, register codes and fixed-point helpers for the point rotate/project unit
// no dependencies
package prp_pkg;

  // register indexes of the configuration port
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_VIEW_MODE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_YAW       = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PITCH     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROLL      = 2'd3;
  localparam int CFG_DATA_W = 16;

  // view mode codes
  localparam logic [2:0] VIEW_XY    = 3'd0;
  localparam logic [2:0] VIEW_XZ    = 3'd1;
  localparam logic [2:0] VIEW_YZ    = 3'd2;
  localparam logic [2:0] VIEW_ISO   = 3'd3;
  localparam logic [2:0] VIEW_PERSP = 3'd4;

  // base angles in 1/65536 turn
  localparam logic [15:0] ISO_YAW   = 16'd8192;
  localparam logic [15:0] ISO_PITCH = 16'd6420;

  // cordic constants, angle unit 2^-32 turn
  localparam int TAB_LEN   = 24;
  localparam int TAB_IDX_W = 5;
  localparam int CRD_W     = 34;
  localparam logic signed [CRD_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [31:0] ATAN_TURN [TAB_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // camera distance 40.0 in q16.16 and quotient width of the divider
  localparam logic signed [33:0] CAM_DIST_Q16 = 34'sd2621440;
  localparam int QUO_W = 32;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } point_in_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth_out;
    logic               point_valid;
  } point_out_t;

  typedef struct packed {
    logic [2:0]  view_mode;
    logic [15:0] yaw_angle;
    logic [15:0] pitch_angle;
    logic [15:0] roll_angle;
  } cfg_t;

  // cosines and sines in q2.30
  typedef struct packed {
    logic signed [31:0] cy;
    logic signed [31:0] sy;
    logic signed [31:0] cp;
    logic signed [31:0] sp;
    logic signed [31:0] cr;
    logic signed [31:0] sr;
  } trig_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] z2;
  } rot_out_t;

  // sum of two q16.16 x q2.30 products, rounded to q16.16 and saturated
  function automatic logic signed [31:0] mix_round(input logic signed [63:0] p0,
                                                   input logic signed [63:0] p1);
    logic signed [65:0] acc;
    logic signed [35:0] sh;
    logic signed [31:0] res;
    acc = 66'(p0) + 66'(p1) + 66'sd536870912;
    sh  = 36'(acc >>> 30);
    if (sh > 36'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (sh < -36'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = sh[31:0];
    end
    return res;
  endfunction

endpackage

// ===== src/prp_trig.sv =====
`timescale 1ns / 1ps
// sine/cosine generator: three cordic lanes stepped once per cycle after reset or a register write
// depends on prp_pkg
module prp_trig #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            restart_i,
  input  prp_pkg::cfg_t   cfg_i,
  output prp_pkg::trig_t  trig_o,
  output logic            busy_o
);
  import prp_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } trig_state_e;

  trig_state_e state_q;
  logic [CNT_W-1:0] cnt_q;

  logic signed [CRD_W-1:0] x_q [3];
  logic signed [CRD_W-1:0] y_q [3];
  logic signed [CRD_W-1:0] z_q [3];
  logic [1:0]              quad_q [3];

  logic                    tilted;
  logic [15:0]             ang [3];
  logic [15:0]             shifted [3];
  logic signed [CRD_W-1:0] z_init [3];
  logic signed [CRD_W-1:0] at;
  logic signed [CRD_W-1:0] cos_v [3];
  logic signed [CRD_W-1:0] sin_v [3];

  assign tilted = (cfg_i.view_mode == VIEW_ISO) || (cfg_i.view_mode == VIEW_PERSP);
  assign ang[0] = cfg_i.yaw_angle + (tilted ? ISO_YAW : 16'd0);
  assign ang[1] = cfg_i.pitch_angle + (tilted ? ISO_PITCH : 16'd0);
  assign ang[2] = cfg_i.roll_angle;
  assign at     = signed'({2'b00, ATAN_TURN[TAB_IDX_W'(cnt_q)]});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      shifted[k] = ang[k] + 16'd8192;
      // residual within one eighth turn, scaled to 2^-32 turn
      z_init[k]  = (CRD_W'($signed({2'b00, shifted[k][13:0]})) - CRD_W'(8192)) <<< 16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
    end else if (restart_i) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          state_q <= ST_RUN;
          cnt_q   <= '0;
        end
        ST_RUN: begin
          if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_DONE: begin
          state_q <= ST_DONE;
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (state_q == ST_LOAD) begin
        x_q[k]    <= CORDIC_GAIN_Q30;
        y_q[k]    <= '0;
        z_q[k]    <= z_init[k];
        quad_q[k] <= shifted[k][15:14];
      end else if (state_q == ST_RUN) begin
        if (!z_q[k][CRD_W-1]) begin
          x_q[k] <= x_q[k] - (y_q[k] >>> cnt_q);
          y_q[k] <= y_q[k] + (x_q[k] >>> cnt_q);
          z_q[k] <= z_q[k] - at;
        end else begin
          x_q[k] <= x_q[k] + (y_q[k] >>> cnt_q);
          y_q[k] <= y_q[k] - (x_q[k] >>> cnt_q);
          z_q[k] <= z_q[k] + at;
        end
      end
    end
  end

  // quadrant fold-back
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (quad_q[k])
        2'd0: begin
          cos_v[k] = x_q[k];
          sin_v[k] = y_q[k];
        end
        2'd1: begin
          cos_v[k] = -y_q[k];
          sin_v[k] = x_q[k];
        end
        2'd2: begin
          cos_v[k] = -x_q[k];
          sin_v[k] = -y_q[k];
        end
        default: begin
          cos_v[k] = y_q[k];
          sin_v[k] = -x_q[k];
        end
      endcase
    end
  end

  assign trig_o.cy = cos_v[0][31:0];
  assign trig_o.sy = sin_v[0][31:0];
  assign trig_o.cp = cos_v[1][31:0];
  assign trig_o.sp = sin_v[1][31:0];
  assign trig_o.cr = cos_v[2][31:0];
  assign trig_o.sr = sin_v[2][31:0];
  assign busy_o    = (state_q != ST_DONE);

endmodule

// ===== src/prp_rot.sv =====
`timescale 1ns / 1ps
// rotation pipeline: yaw, pitch and roll as multiply stage then round/saturate stage
// depends on prp_pkg
module prp_rot (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  prp_pkg::point_in_t  in_data_i,
  input  prp_pkg::trig_t      trig_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output prp_pkg::rot_out_t   out_data_o
);
  import prp_pkg::*;

  localparam int NS = 6;

  logic [NS-1:0] v_q;
  logic          en;

  logic signed [63:0] p1_q [4];
  logic signed [31:0] py1_q;
  logic signed [31:0] x1_q, z1_q, py2_q;
  logic signed [63:0] p3_q [4];
  logic signed [31:0] x13_q;
  logic signed [31:0] x14_q, y1_q, z2_q;
  logic signed [63:0] p5_q [4];
  logic signed [31:0] z25_q;
  logic signed [31:0] rx_q, ry_q, z26_q;

  // whole pipeline moves unless the last stage holds an untaken item
  assign en = !v_q[NS-1] || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // yaw about y
      p1_q[0] <= in_data_i.pos_x * trig_i.cy;
      p1_q[1] <= in_data_i.pos_z * (-trig_i.sy);
      p1_q[2] <= in_data_i.pos_x * trig_i.sy;
      p1_q[3] <= in_data_i.pos_z * trig_i.cy;
      py1_q   <= in_data_i.pos_y;
      x1_q    <= mix_round(p1_q[0], p1_q[1]);
      z1_q    <= mix_round(p1_q[2], p1_q[3]);
      py2_q   <= py1_q;
      // pitch about x
      p3_q[0] <= py2_q * trig_i.cp;
      p3_q[1] <= z1_q * (-trig_i.sp);
      p3_q[2] <= py2_q * trig_i.sp;
      p3_q[3] <= z1_q * trig_i.cp;
      x13_q   <= x1_q;
      y1_q    <= mix_round(p3_q[0], p3_q[1]);
      z2_q    <= mix_round(p3_q[2], p3_q[3]);
      x14_q   <= x13_q;
      // roll about z
      p5_q[0] <= x14_q * trig_i.cr;
      p5_q[1] <= y1_q * (-trig_i.sr);
      p5_q[2] <= x14_q * trig_i.sr;
      p5_q[3] <= y1_q * trig_i.cr;
      z25_q   <= z2_q;
      rx_q    <= mix_round(p5_q[0], p5_q[1]);
      ry_q    <= mix_round(p5_q[2], p5_q[3]);
      z26_q   <= z25_q;
    end
  end

  assign in_ready_o    = en;
  assign out_valid_o   = v_q[NS-1];
  assign out_data_o.rx = rx_q;
  assign out_data_o.ry = ry_q;
  assign out_data_o.z2 = z26_q;

endmodule

// ===== src/prp_div.sv =====
`timescale 1ns / 1ps
// view select and perspective divide: restoring divider, one quotient bit per stage
// depends on prp_pkg
module prp_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          view_mode_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  prp_pkg::rot_out_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output prp_pkg::point_out_t out_data_o
);
  import prp_pkg::*;

  localparam int NS = QUO_W + 4;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [31:0] r;
    logic [31:0] n;
    logic [31:0] q;
  } div_lane_t;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] depth;
    logic               persp;
    logic               ok;
    logic [31:0]        denom;
    div_lane_t          lx;
    div_lane_t          ly;
  } div_stage_t;

  function automatic div_lane_t lane_step(input div_lane_t l, input logic [31:0] d);
    div_lane_t  o;
    logic [32:0] rr;
    o  = l;
    rr = {l.r, l.n[31]};
    if (rr >= {1'b0, d}) begin
      o.r = 32'(rr - {1'b0, d});
      o.q = {l.q[30:0], 1'b1};
    end else begin
      o.r = rr[31:0];
      o.q = {l.q[30:0], 1'b0};
    end
    o.n = {l.n[30:0], 1'b0};
    return o;
  endfunction

  // one divider stage: both lanes take one quotient bit, the rest rides along
  function automatic div_stage_t stage_step(input div_stage_t s);
    div_stage_t o;
    o    = s;
    o.lx = lane_step(s.lx, s.denom);
    o.ly = lane_step(s.ly, s.denom);
    return o;
  endfunction

  function automatic logic signed [31:0] quot_sat(input div_lane_t l);
    logic signed [31:0] res;
    if (!l.neg) begin
      res = (l.ovf || l.q[31]) ? 32'sh7fffffff : $signed(l.q);
    end else begin
      res = (l.ovf || (l.q > 32'h80000000)) ? 32'sh80000000 : $signed(~l.q + 32'd1);
    end
    return res;
  endfunction

  logic [NS-1:0] v_q;
  logic          en;

  // stage 0: view select, denominator, magnitudes
  logic signed [31:0] sel_x, sel_y, sel_d;
  logic signed [31:0] sx0_q, sy0_q, d0_q;
  logic signed [33:0] den0_q;
  logic [31:0]        mx0_q, my0_q;
  logic               persp0_q;

  // stage 1: validity and scaled dividends
  logic signed [35:0] den3;
  logic signed [31:0] sx1_q, sy1_q, d1_q;
  logic [31:0]        den1_q;
  logic [54:0]        nx1_q, ny1_q;
  logic               nx_neg1_q, ny_neg1_q, persp1_q, ok1_q;

  div_stage_t st_q [QUO_W+1];
  div_stage_t st0;
  point_out_t res_q;

  assign en = !v_q[NS-1] || out_ready_i;

  always_comb begin
    case (view_mode_i)
      VIEW_XZ: begin
        sel_x = in_data_i.rx;
        sel_y = in_data_i.z2;
        sel_d = in_data_i.ry;
      end
      VIEW_YZ: begin
        sel_x = in_data_i.ry;
        sel_y = in_data_i.z2;
        sel_d = in_data_i.rx;
      end
      default: begin
        sel_x = in_data_i.rx;
        sel_y = in_data_i.ry;
        sel_d = in_data_i.z2;
      end
    endcase
  end

  assign den3 = (36'(den0_q) <<< 1) + 36'(den0_q);

  always_comb begin
    st0.sx     = sx1_q;
    st0.sy     = sy1_q;
    st0.depth  = d1_q;
    st0.persp  = persp1_q;
    st0.ok     = ok1_q;
    st0.denom  = den1_q;
    st0.lx.neg = nx_neg1_q;
    st0.lx.ovf = {9'd0, nx1_q[54:32]} >= den1_q;
    st0.lx.r   = {9'd0, nx1_q[54:32]};
    st0.lx.n   = nx1_q[31:0];
    st0.lx.q   = '0;
    st0.ly.neg = ny_neg1_q;
    st0.ly.ovf = {9'd0, ny1_q[54:32]} >= den1_q;
    st0.ly.r   = {9'd0, ny1_q[54:32]};
    st0.ly.n   = ny1_q[31:0];
    st0.ly.q   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx0_q    <= sel_x;
      sy0_q    <= sel_y;
      d0_q     <= sel_d;
      den0_q   <= CAM_DIST_Q16 - 34'(sel_d);
      mx0_q    <= sel_x[31] ? (~sel_x + 32'd1) : sel_x;
      my0_q    <= sel_y[31] ? (~sel_y + 32'd1) : sel_y;
      persp0_q <= (view_mode_i == VIEW_PERSP);

      sx1_q     <= sx0_q;
      sy1_q     <= sy0_q;
      d1_q      <= d0_q;
      den1_q    <= den0_q[31:0];
      persp1_q  <= persp0_q;
      ok1_q     <= !persp0_q || (den3 >= 36'sd262144);
      nx_neg1_q <= sx0_q[31];
      ny_neg1_q <= sy0_q[31];
      // |s| * 40 * 2^16 plus half the divisor for rounding
      nx1_q     <= {((38'(mx0_q) << 5) + (38'(mx0_q) << 3)), 16'd0}
                   + 55'(den0_q[31:1]);
      ny1_q     <= {((38'(my0_q) << 5) + (38'(my0_q) << 3)), 16'd0}
                   + 55'(den0_q[31:1]);

      st_q[0] <= st0;
      for (int j = 1; j <= QUO_W; j++) begin
        st_q[j] <= stage_step(st_q[j-1]);
      end

      res_q.depth_out <= st_q[QUO_W].depth;
      if (!st_q[QUO_W].persp) begin
        res_q.screen_x    <= st_q[QUO_W].sx;
        res_q.screen_y    <= st_q[QUO_W].sy;
        res_q.point_valid <= 1'b1;
      end else if (st_q[QUO_W].ok) begin
        res_q.screen_x    <= quot_sat(st_q[QUO_W].lx);
        res_q.screen_y    <= quot_sat(st_q[QUO_W].ly);
        res_q.point_valid <= 1'b1;
      end else begin
        res_q.screen_x    <= '0;
        res_q.screen_y    <= '0;
        res_q.point_valid <= 1'b0;
      end
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = res_q;

endmodule

// ===== src/point_rotate_project_unit.sv =====
`timescale 1ns / 1ps
// top level of the point rotate/project unit: registers, trig generator, pipelines, output skid
// depends on prp_pkg, prp_trig, prp_rot, prp_div
//
// usage
// - input channel in_valid_i/in_ready_o carries one q16.16 point per transaction
// - output channel out_valid_o/out_ready_i carries screen x/y, depth and a valid flag
// - configuration: write cfg_wdata_i to register cfg_idx_i when cfg_we_i is high
//   (0 view mode, 1 yaw, 2 pitch, 3 roll); write only while no transaction is in flight
// - path from input transaction to result: 6 rotation stages,
//   36 divider stages, one output register
// - throughput: one point per cycle unless input is held off; the perspective divide is a restoring
//   divider with one quotient bit per stage, so every point takes the same path
// - after reset and after every register write the three cordic lanes recompute
//   sine and cosine; in_ready_o stays low meanwhile
// - receiver stall: a two-entry output buffer (output register plus skid register)
//   keeps taking results while the head waits; once it is full each pipeline holds
//   as a whole, moving on only while its last stage is empty
module point_rotate_project_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  prp_pkg::point_in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output prp_pkg::point_out_t                  out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [prp_pkg::REG_IDX_W-1:0]        cfg_idx_i,
  input  logic [prp_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);
  import prp_pkg::*;

  cfg_t       cfg_q;
  trig_t      trig;
  logic       trig_busy;

  logic       rot_in_ready;
  logic       rot_valid;
  rot_out_t   rot_data;
  logic       div_in_ready;
  logic       div_valid;
  point_out_t div_data;

  // output buffer
  logic       ov_q, sv_q;
  point_out_t out_q, sk_q;
  logic       buf_ready;
  logic       head_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VIEW_MODE: cfg_q.view_mode   <= cfg_wdata_i[2:0];
        REG_YAW:       cfg_q.yaw_angle   <= cfg_wdata_i;
        REG_PITCH:     cfg_q.pitch_angle <= cfg_wdata_i;
        REG_ROLL:      cfg_q.roll_angle  <= cfg_wdata_i;
        default:       cfg_q             <= cfg_q;
      endcase
    end
  end

  // sine and cosine of the three angles, recomputed on any write
  prp_trig #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_trig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .cfg_i     (cfg_q),
    .trig_o    (trig),
    .busy_o    (trig_busy)
  );

  // input transactions are held off while the trig values settle
  prp_rot u_rot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i && !trig_busy),
    .in_ready_o  (rot_in_ready),
    .in_data_i   (in_data_i),
    .trig_i      (trig),
    .out_valid_o (rot_valid),
    .out_ready_i (div_in_ready),
    .out_data_o  (rot_data)
  );

  prp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .view_mode_i (cfg_q.view_mode),
    .in_valid_i  (rot_valid),
    .in_ready_o  (div_in_ready),
    .in_data_i   (rot_data),
    .out_valid_o (div_valid),
    .out_ready_i (buf_ready),
    .out_data_o  (div_data)
  );

  // skid buffer: ready towards the pipeline is a register
  assign buf_ready = !sv_q;
  assign head_free = !ov_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (head_free) begin
      if (sv_q) begin
        ov_q <= 1'b1;
        sv_q <= 1'b0;
      end else begin
        ov_q <= div_valid;
      end
    end else if (div_valid && buf_ready) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_free) begin
      out_q <= sv_q ? sk_q : div_data;
    end else if (div_valid && buf_ready) begin
      sk_q <= div_data;
    end
  end

  assign in_ready_o  = rot_in_ready && !trig_busy;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/prp_checker.sv =====
`timescale 1ns / 1ps
// port-level checker for the point rotate/project unit, bound to the top level
// depends on prp_pkg
module prp_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input prp_pkg::point_out_t                  out_data_o,
  input logic                                 cfg_we_i
);
  import prp_pkg::*;

  logic [7:0] inflight_q;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 8'(in_fire) - 8'(out_fire);
    end
  end

  // a held result does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a register write restarts the trig lanes and blocks input
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o)
    else $error("input taken while trig values recompute");

  // rejected points carry zero screen coordinates
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.point_valid |->
      out_data_o.screen_x == 32'sd0 && out_data_o.screen_y == 32'sd0)
    else $error("rejected point with non-zero coordinates");

  // no result without a transaction in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 8'd0)
    else $error("result without matching input transaction");

endmodule

bind point_rotate_project_unit prp_checker u_prp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_we_i    (cfg_we_i)
);
